>>> rtl/wildcard_glob_matcher_unit_defines.svh
// Assertion macros shared by the wildcard matcher checker.
// No dependencies; included by files that carry assertions.
`ifndef WILDCARD_GLOB_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define WGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wgm_pkg.sv
// Shared types and constants of the wildcard matcher.
// No dependencies; used by the cell and the top level.
package wgm_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    localparam logic [7:0] SYM_ANY_ONE = 8'h3F;  // '?'
    localparam logic [7:0] SYM_ANY_RUN = 8'h2A;  // '*'

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       append;   // write sym into the cell at the fill count
        logic       text;     // advance on text byte sym
        logic       restart;  // back to position zero
        logic [7:0] sym;
    } t_cell_ctl;

    // Returned by every cell.
    typedef struct packed {
        logic raw;    // active bit before the star closure
        logic prop;   // cell holds a '*' within the pattern
    } t_cell_stat;

endpackage

>>> rtl/wgm_if.sv
// Request and response channel interfaces of the wildcard matcher.
// No dependencies.
interface wgm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] symbol;
    modport source(output valid, command, symbol, input ready);
    modport sink(input valid, command, symbol, output ready);
endinterface

interface wgm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic truncated;
    logic no_live_position;
    modport source(output valid, matched, truncated, no_live_position, input ready);
    modport sink(input valid, matched, truncated, no_live_position, output ready);
endinterface

>>> rtl/wildcard_glob_matcher_unit.sv
// Top level of the wildcard matcher: cell row, closure, report stage.
// Depends on wgm_pkg, wgm_if, wgm_cell and wgm_closure.
//
//  channel | dir | fields                                    | produces result
//  --------+-----+-------------------------------------------+-----------------
//  i_req   | in  | command[1:0], symbol[7:0]                 | text, restart
//  o_rsp   | out | matched, truncated, no_live_position      | -
//
// One request per cycle while i_req is not stalled. A text or restart request
// queues a report; the report stage reads the cell row after the row
// updates. The row update is one byte compare per cell plus the closure
// carry chain across MAX_PATTERN+1 positions.
// Reset (synchronous): empty pattern, position zero live, no flag.
// A stalled response holds in o_rsp; i_req stalls only in reset or when a
// report is waiting behind it.
module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wgm_req_if.sink       i_req,
    wgm_rsp_if.source     o_rsp
);
    import wgm_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int W  = MAX_PATTERN + 1;

    // fill count and overflow flag
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_ovf;
    logic          n_ovf;

    // report handshake
    logic          r_pend;
    logic          n_pend;
    logic          r_ov;
    logic          r_matched;
    logic          r_trunc;
    logic          r_nolive;

    logic          w_acc;
    logic          w_room;
    logic          w_move;
    t_cmd          w_cmd;
    t_cell_ctl     w_ctl;

    // row signals
    logic [W-1:0]  w_raw;
    logic [W-1:0]  w_prop;
    logic [W-1:0]  w_closed;
    logic [W-1:0]  w_tail;
    logic [W:0]    w_adv;     // hand-off chain; bit g feeds cell g
    t_cell_stat    w_stat [W];

    assign w_cmd  = t_cmd'(i_req.command);
    assign w_room = r_count < CW'(MAX_PATTERN);

    // Response slot frees up when empty or drained this cycle.
    assign w_move      = r_pend && (!r_ov || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_pend || !r_ov || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    always_comb begin
        w_ctl.append  = 1'b0;
        w_ctl.text    = 1'b0;
        w_ctl.restart = 1'b0;
        w_ctl.sym     = i_req.symbol;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_pend        = w_move ? 1'b0 : r_pend;
        if (w_acc) begin
            case (w_cmd)
                CMD_APPEND: begin
                    w_ctl.restart = 1'b1;
                    if (w_room) begin
                        w_ctl.append = 1'b1;
                        n_count      = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                CMD_TEXT: begin
                    w_ctl.text = 1'b1;
                    n_pend     = 1'b1;
                end
                CMD_RESTART: begin
                    w_ctl.restart = 1'b1;
                    n_pend        = 1'b1;
                end
                default: begin   // clear
                    w_ctl.restart = 1'b1;
                    n_count       = '0;
                    n_ovf         = 1'b0;
                end
            endcase
        end
    end

    // Cell row: each cell hands its consumed-byte bit to its right neighbor.
    assign w_adv[0] = 1'b0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        wgm_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .IDX         (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_count  (r_count),
            .i_closed (w_closed[g]),
            .i_adv    (w_adv[g]),
            .o_adv    (w_adv[g+1]),
            .o_stat   (w_stat[g])
        );
        assign w_raw[g]  = w_stat[g].raw;
        assign w_prop[g] = w_stat[g].prop;
        assign w_tail[g] = r_count == CW'(g);
    end

    // Stored active bits are pre-closure; closure is applied on every read.
    wgm_closure #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_closure (
        .i_raw    (w_raw),
        .i_prop   (w_prop),
        .o_closed (w_closed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            if (w_move) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Report from the row as it stands after the request that asked for it.
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_matched <= |(w_closed & w_tail);
            r_trunc   <= r_ovf;
            r_nolive  <= ~|w_closed;
        end
    end

    assign o_rsp.valid            = r_ov;
    assign o_rsp.matched          = r_matched;
    assign o_rsp.truncated        = r_trunc;
    assign o_rsp.no_live_position = r_nolive;

endmodule

>>> rtl/wgm_cell.sv
// One pattern position: stored symbol, active bit, hand-off to the next cell.
// Depends on wgm_pkg.
module wgm_cell #(
    parameter int MAX_PATTERN = 64,
    parameter int IDX = 0,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wgm_pkg::t_cell_ctl    i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic                  i_closed,
    input  logic                  i_adv,
    output logic                  o_adv,
    output wgm_pkg::t_cell_stat   o_stat
);
    import wgm_pkg::*;

    localparam logic START_ACT = (IDX == 0);

    logic [7:0] r_sym;
    logic       r_act;
    logic       n_act;
    logic       w_valid;
    logic       w_star;
    logic       w_hit;

    assign w_valid = i_count > CW'(IDX);
    assign w_star  = r_sym == SYM_ANY_RUN;
    assign w_hit   = (r_sym == SYM_ANY_ONE) || (r_sym == i_ctl.sym);

    // a live non-star position consumes the byte and hands on
    assign o_adv = i_closed & w_valid & ~w_star & w_hit;

    assign o_stat.raw  = r_act;
    assign o_stat.prop = w_valid & w_star;

    always_comb begin
        n_act = r_act;
        if (i_ctl.restart) begin
            n_act = START_ACT;
        end else if (i_ctl.text) begin
            n_act = (i_closed & w_valid & w_star) | i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= START_ACT;
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (i_count == CW'(IDX))) begin
            r_sym <= i_ctl.sym;
        end
    end

endmodule

>>> rtl/wgm_closure.sv
// Empty-match closure of '*' over the whole row, as one carry chain.
// No dependencies.
module wgm_closure #(
    parameter int MAX_PATTERN = 64,
    localparam int W = MAX_PATTERN + 1
) (
    input  logic [W-1:0] i_raw,
    input  logic [W-1:0] i_prop,
    output logic [W-1:0] o_closed
);
    logic [W-1:0] w_gen;
    logic [W-1:0] w_sum;

    // A live star seeds a carry that runs through the star run and lands on
    // the first non-star position; every bit the carry touches flips.
    // The top position never propagates, so no carry is lost.
    assign w_gen    = i_raw & i_prop;
    assign w_sum    = i_prop + w_gen;
    assign o_closed = i_raw | (w_sum ^ i_prop);

endmodule

>>> rtl/wgm_chk.sv
// Port-level checker for the wildcard matcher, bound to the top level.
// Depends on wildcard_glob_matcher_unit_defines.svh and wgm_pkg.
`include "wildcard_glob_matcher_unit_defines.svh"

module wgm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_command,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_matched,
    input logic       i_truncated,
    input logic       i_no_live
);
    import wgm_pkg::*;

    logic w_rep_acc;

    assign w_rep_acc = i_req_valid && i_req_ready &&
                       ((i_req_command == CMD_TEXT) || (i_req_command == CMD_RESTART));

    `WGM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")

    `WGM_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable({i_matched, i_truncated, i_no_live}), "stalled response changed")

    `WGM_ASSERT_NOW(a_match_live, i_clk, i_rst_n, i_rsp_valid, !(i_matched && i_no_live), "match reported with no live position")

    `WGM_ASSERT_NOW(a_rsp_cause, i_clk, i_rst_n, $rose(i_rsp_valid), $past(w_rep_acc, 2), "response without a text or restart request")

endmodule

bind wildcard_glob_matcher_unit wgm_chk u_wgm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_command (i_req.command),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_matched     (o_rsp.matched),
    .i_truncated   (o_rsp.truncated),
    .i_no_live     (o_rsp.no_live_position)
);
